FILE: rtl/core/ckeb_pkg.sv
// ----------------------------------------------------------------------------
// Color key edge bleed package
// Shared types, constants and helper functions for the key bleed filter.
// ----------------------------------------------------------------------------
package ckeb_pkg;

  // Line store depth and counter widths.
  localparam int LINE_DEPTH  = 2048;
  localparam int MAX_LINES   = 4096;
  localparam int COL_W       = 11;
  localparam int WID_W       = 12;
  localparam int HGT_W       = 13;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;

  // Command queue between the front and back parts.
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = 2;

  // Neighbor sums and reciprocal division.
  localparam int SUM_W       = 11;
  localparam int CNT_W       = 4;
  localparam int RECIP_W     = 17;
  localparam int RECIP_SHIFT = 16;
  localparam int PROD_W      = SUM_W + RECIP_W;

  // Key color thresholds and the opaque alpha value.
  localparam logic [7:0] KEY_HI       = 8'd250;
  localparam logic [7:0] KEY_LO       = 8'd5;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_IMAGE_HEIGHT  = 2'd1,
    CFG_THREE_CHANNEL = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic       drain;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       frame_end;
  } out_item_t;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  // Effective frame settings after clamping.
  typedef struct packed {
    logic [WID_W-1:0] width;
    logic [HGT_W-1:0] height;
    logic             three_ch;
  } frame_cfg_t;

  // One classified step for the back part.
  typedef struct packed {
    logic [COL_W-1:0] col;
    pixel_t           pixel;
    logic             emit;
    logic             left;
    logic             right;
    logic             top;
    logic             bottom;
    logic             frame_end;
  } cmd_t;

  function automatic logic is_key(pixel_t p);
    return (p.red > KEY_HI) && (p.green < KEY_LO) && (p.blue > KEY_HI);
  endfunction

  // Rounded-up 2^16 / n; exact floor division for sums up to 8 * 255.
  function automatic logic [RECIP_W-1:0] recip(logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/color_key_edge_bleed_filter.sv
// ----------------------------------------------------------------------------
// Color key edge bleed filter
// Replaces magenta key pixels by the average of their 3x3 neighbors.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the in_ channel (valid/stall) and leave on
// the out_ channel in the same order. A key pixel gets the truncated average
// RGB of its usable neighbors and alpha 0; other pixels pass unchanged.
// The block takes one transfer per clock while in_stall is low. A pixel's result
// is produced by the input step W+1 steps later and is offered once that
// transfer has passed the command queue, stage one, the window sum stage
// and the output register.
// After the last pixel of a frame, W+1 input transfers (drain or not) flush
// the final line; pixels sent during that phase are dropped. A drain
// transfer outside the flush phase is taken and ignored.
// Configuration writes (cfg_we, cfg_index, cfg_data) to a known register
// restart the frame; the user must make them only while the block is idle,
// as the block does not enforce it. Reset clears the position counters and
// pipeline and loads 640 x 480 RGBA; the line stores are not cleared, as
// unwritten entries only feed masked neighbors. When out_stall is high while
// a result is offered the back end holds, the command queue fills and in_stall rises.
// ----------------------------------------------------------------------------
module color_key_edge_bleed_filter import ckeb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  frame_cfg_t       cfg_r, cfg_nxt;
  logic             restart;
  logic [WID_W-1:0] width_raw, width_eff;
  logic [HGT_W-1:0] height_raw, height_eff;

  logic q_push, q_full, q_pop, q_valid;
  cmd_t push_cmd, head_cmd;

  // Clamp written sizes to the supported range.
  assign width_raw  = cfg_data[WID_W-1:0];
  assign height_raw = cfg_data[HGT_W-1:0];

  always_comb begin
    if (width_raw == '0) begin
      width_eff = WID_W'(1);
    end else if (width_raw > WID_W'(LINE_DEPTH)) begin
      width_eff = WID_W'(LINE_DEPTH);
    end else begin
      width_eff = width_raw;
    end
    if (height_raw == '0) begin
      height_eff = HGT_W'(1);
    end else if (height_raw > HGT_W'(MAX_LINES)) begin
      height_eff = HGT_W'(MAX_LINES);
    end else begin
      height_eff = height_raw;
    end
  end

  // Register decode; a write to a known register restarts the frame.
  always_comb begin
    cfg_nxt = cfg_r;
    restart = 1'b0;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH: begin
          cfg_nxt.width = width_eff;
          restart       = 1'b1;
        end
        CFG_IMAGE_HEIGHT: begin
          cfg_nxt.height = height_eff;
          restart        = 1'b1;
        end
        CFG_THREE_CHANNEL: begin
          cfg_nxt.three_ch = cfg_data[0];
          restart          = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width    <= WID_W'(640);
      cfg_r.height   <= HGT_W'(480);
      cfg_r.three_ch <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ckeb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .restart  (restart),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  ckeb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head_cmd  (head_cmd)
  );

  ckeb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (head_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/core/ckeb_front.sv
// ----------------------------------------------------------------------------
// Key bleed front end
// Accepts input transfers, tracks the raster position and drain phase, and
// turns each step into a classified command for the back end.
// ----------------------------------------------------------------------------
module ckeb_front import ckeb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  frame_cfg_t cfg,
  input  logic       restart,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  logic [COL_W-1:0] x_r, x_nxt;
  logic [HGT_W-1:0] r_r, r_nxt;
  logic             draining;
  logic             x_zero;
  logic             in_acc;
  logic             line_end;

  // Rows at or past the frame height are the flush phase.
  assign draining = (r_r >= cfg.height);
  assign x_zero   = (x_r == '0);
  assign in_acc   = in_valid && !q_full;
  assign in_stall = q_full;
  assign q_push   = in_acc && (draining || !in_data.drain);
  assign line_end = (({1'b0, x_r} + WID_W'(1)) == cfg.width);

  // Classify the step: which window position is emitted and its borders.
  always_comb begin
    q_cmd.col = x_r;
    if (draining) begin
      q_cmd.pixel = '0;
    end else begin
      q_cmd.pixel.red   = in_data.red_in;
      q_cmd.pixel.green = in_data.green_in;
      q_cmd.pixel.blue  = in_data.blue_in;
      q_cmd.pixel.alpha = cfg.three_ch ? ALPHA_OPAQUE : in_data.alpha_in;
    end
    if (x_zero) begin
      q_cmd.emit      = (r_r >= HGT_W'(2));
      q_cmd.left      = (cfg.width != WID_W'(1));
      q_cmd.right     = 1'b0;
      q_cmd.top       = (r_r >= HGT_W'(3));
      q_cmd.bottom    = (r_r <= cfg.height);
      q_cmd.frame_end = (r_r > cfg.height);
    end else begin
      q_cmd.emit      = (r_r >= HGT_W'(1));
      q_cmd.left      = (x_r >= COL_W'(2));
      q_cmd.right     = 1'b1;
      q_cmd.top       = (r_r >= HGT_W'(2));
      q_cmd.bottom    = (r_r < cfg.height);
      q_cmd.frame_end = 1'b0;
    end
  end

  // Raster position; the extra flush row holds a single step.
  always_comb begin
    x_nxt = x_r;
    r_nxt = r_r;
    if (restart) begin
      x_nxt = '0;
      r_nxt = '0;
    end else if (q_push) begin
      if (r_r > cfg.height) begin
        x_nxt = '0;
        r_nxt = '0;
      end else if (line_end) begin
        x_nxt = '0;
        r_nxt = r_r + HGT_W'(1);
      end else begin
        x_nxt = x_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      r_r <= '0;
    end else begin
      x_r <= x_nxt;
      r_r <= r_nxt;
    end
  end

endmodule

FILE: rtl/core/ckeb_queue.sv
// ----------------------------------------------------------------------------
// Key bleed command queue
// Short FIFO that lets the front and back ends stall independently.
// ----------------------------------------------------------------------------
module ckeb_queue import ckeb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output cmd_t head_cmd
);

  cmd_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign full      = (count_r == (QPTR_W+1)'(QDEPTH));
  assign not_empty = (count_r != '0);
  assign head_cmd  = slot_r[rd_ptr_r];

  // Storage slots.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

FILE: rtl/core/ckeb_back.sv
// ----------------------------------------------------------------------------
// Key bleed back end
// Line stores, 3x3 window, neighbor averaging and the output register.
// ----------------------------------------------------------------------------
module ckeb_back import ckeb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  cmd_t      q_cmd,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  pixel_t up_mem  [LINE_DEPTH];
  pixel_t mid_mem [LINE_DEPTH];

  logic   adv;
  logic   s1_valid_r;
  cmd_t   s1_cmd_r;
  pixel_t up_rd_r, mid_rd_r;
  logic   fwd_r;
  pixel_t fwd_up_r, fwd_mid_r;
  pixel_t up_eff, mid_eff;

  pixel_t win_c1_r [3];
  pixel_t win_c2_r [3];
  pixel_t new_col  [3];

  logic [SUM_W-1:0] sum_red, sum_green, sum_blue;
  logic [CNT_W-1:0] cnt;

  logic             s2_valid_r;
  pixel_t           s2_center_r;
  logic             s2_key_r;
  logic [SUM_W-1:0] s2_red_r, s2_green_r, s2_blue_r;
  logic [CNT_W-1:0] s2_cnt_r;
  logic             s2_end_r;

  logic [RECIP_W-1:0] inv;
  logic [PROD_W-1:0]  prod_red, prod_green, prod_blue;
  out_item_t          res;
  logic               out_valid_r;
  out_item_t          out_data_r;

  // The whole back pipeline moves unless the output register is held.
  assign adv       = !out_valid_r || !out_stall;
  assign q_pop     = adv && q_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Line store read data, with bypass of the write from the stage ahead.
  assign up_eff  = fwd_r ? fwd_up_r  : up_rd_r;
  assign mid_eff = fwd_r ? fwd_mid_r : mid_rd_r;

  // Line stores: read at pop, written at the same column when the command leaves stage one.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      up_rd_r  <= up_mem[q_cmd.col];
      mid_rd_r <= mid_mem[q_cmd.col];
    end
    if (adv && s1_valid_r) begin
      up_mem[s1_cmd_r.col]  <= mid_eff;
      mid_mem[s1_cmd_r.col] <= s1_cmd_r.pixel;
    end
  end

  // Stage one command and bypass capture.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_cmd_r  <= q_cmd;
      fwd_r     <= s1_valid_r && adv && (s1_cmd_r.col == q_cmd.col);
      fwd_up_r  <= mid_eff;
      fwd_mid_r <= s1_cmd_r.pixel;
    end
  end

  // Window columns shift in on each step.
  assign new_col[0] = up_eff;
  assign new_col[1] = mid_eff;
  assign new_col[2] = s1_cmd_r.pixel;

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      for (int i = 0; i < 3; i++) begin
        win_c1_r[i] <= win_c2_r[i];
        win_c2_r[i] <= new_col[i];
      end
    end
  end

  // Sum the in-frame neighbors that are neither key color nor transparent.
  always_comb begin
    pixel_t q;
    logic   use_q;
    sum_red   = '0;
    sum_green = '0;
    sum_blue  = '0;
    cnt       = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (c == 0) begin
          q = win_c1_r[r];
        end else if (c == 1) begin
          q = win_c2_r[r];
        end else begin
          q = new_col[r];
        end
        use_q = (r != 0 || s1_cmd_r.top) && (r != 2 || s1_cmd_r.bottom) &&
                (c != 0 || s1_cmd_r.left) && (c != 2 || s1_cmd_r.right) &&
                !is_key(q) && (q.alpha != 8'd0);
        if (use_q) begin
          sum_red   = sum_red   + SUM_W'(q.red);
          sum_green = sum_green + SUM_W'(q.green);
          sum_blue  = sum_blue  + SUM_W'(q.blue);
          cnt       = cnt + CNT_W'(1);
        end
      end
    end
  end

  // Stage two: sums and the center pixel.
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_center_r <= win_c2_r[1];
      s2_key_r    <= is_key(win_c2_r[1]);
      s2_red_r    <= sum_red;
      s2_green_r  <= sum_green;
      s2_blue_r   <= sum_blue;
      s2_cnt_r    <= cnt;
      s2_end_r    <= s1_cmd_r.frame_end;
    end
  end

  // Average by multiplying with the reciprocal of the count.
  assign inv        = recip(s2_cnt_r);
  assign prod_red   = PROD_W'(s2_red_r)   * PROD_W'(inv);
  assign prod_green = PROD_W'(s2_green_r) * PROD_W'(inv);
  assign prod_blue  = PROD_W'(s2_blue_r)  * PROD_W'(inv);

  always_comb begin
    res.red_out   = s2_center_r.red;
    res.green_out = s2_center_r.green;
    res.blue_out  = s2_center_r.blue;
    res.alpha_out = s2_center_r.alpha;
    res.frame_end = s2_end_r;
    if (s2_key_r) begin
      res.alpha_out = 8'd0;
      if (s2_cnt_r != '0) begin
        res.red_out   = prod_red[RECIP_SHIFT +: 8];
        res.green_out = prod_green[RECIP_SHIFT +: 8];
        res.blue_out  = prod_blue[RECIP_SHIFT +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res;
    end
  end

  // Valid flags of the pipeline stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= q_valid;
      s2_valid_r  <= s1_valid_r && s1_cmd_r.emit;
      out_valid_r <= s2_valid_r;
    end
  end

endmodule

FILE: tb/sv/color_key_edge_bleed_filter_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Color key edge bleed filter testbench
// Streams raster frames through the filter under random idling on both sides
// and checks every output transfer against a local model of the 3x3 bleed.
// ----------------------------------------------------------------------------
module color_key_edge_bleed_filter_test;
  import ckeb_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_ITEMS  = 1250;
  localparam int QUIET_AFTER   = 1100;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int EXTREME_ITEMS = 100;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  color_key_edge_bleed_filter dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Frame model state: line stores, window, raster position and flush count.
  logic [31:0] row_above [LINE_DEPTH];
  logic [31:0] row_prev [LINE_DEPTH];
  logic [31:0] window [9];
  int          col_pos;
  int          row_pos;
  int          flush_left;
  int          width_reg;
  int          height_reg;
  bit          rgb_only;

  out_item_t   fresh_px[$];
  out_item_t   owed_px[$];
  int          mismatches;
  int          random_sent;
  bit          quiet;
  bit          hold_req;
  bit          hold_done;
  bit          sender_gaps;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int frame_w();
    if (width_reg < 1) return 1;
    if (width_reg > LINE_DEPTH) return LINE_DEPTH;
    return width_reg;
  endfunction

  function automatic int frame_h();
    if (height_reg < 1) return 1;
    if (height_reg > MAX_LINES) return MAX_LINES;
    return height_reg;
  endfunction

  function automatic bit keyed(logic [31:0] p);
    return (p[7:0] > 8'd250) && (p[15:8] < 8'd5) && (p[23:16] > 8'd250);
  endfunction

  function automatic void shift_window(int x, logic [31:0] px);
    for (int r = 0; r < 3; r++) begin
      window[r*3]   = window[r*3+1];
      window[r*3+1] = window[r*3+2];
    end
    window[2] = row_above[x];
    window[5] = row_prev[x];
    window[8] = px;
    row_above[x] = row_prev[x];
    row_prev[x] = px;
  endfunction

  // Center pixel at window column c, frame position (cx, cy).
  function automatic void bleed_center(int c, int cx, int cy);
    logic [31:0] p;
    logic [31:0] q;
    int          sr, sg, sb, n, w, h;
    out_item_t   o;
    w = frame_w();
    h = frame_h();
    p = window[3+c];
    if (keyed(p)) begin
      sr = 0; sg = 0; sb = 0; n = 0;
      for (int dr = -1; dr <= 1; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          if ((dr < 0 && cy < 1) || (dr > 0 && cy + 1 >= h)) continue;
          if ((dc < 0 && cx < 1) || (dc > 0 && cx + 1 >= w)) continue;
          q = window[(dr+1)*3 + c + dc];
          if (keyed(q) || q[31:24] == 8'd0) continue;
          sr += q[7:0];
          sg += q[15:8];
          sb += q[23:16];
          n++;
        end
      end
      if (n > 0) p = {8'd0, 8'(sb / n), 8'(sg / n), 8'(sr / n)};
      p[31:24] = 8'd0;
    end
    o.red_out   = p[7:0];
    o.green_out = p[15:8];
    o.blue_out  = p[23:16];
    o.alpha_out = p[31:24];
    o.frame_end = (cx == w - 1) && (cy == h - 1);
    fresh_px.push_back(o);
  endfunction

  function automatic void advance_raster(int x, int r, logic [31:0] px);
    int h;
    h = frame_h();
    if (x == 0) begin
      if (r >= 2) bleed_center(2, frame_w() - 1, r - 2);
      if (r <= h) shift_window(0, px);
    end else begin
      shift_window(x, px);
      if (r >= 1) bleed_center(1, x - 1, r - 1);
    end
  endfunction

  // One accepted input transfer; results land in fresh_px.
  function automatic void filter_step(in_item_t it);
    logic [31:0] px;
    int          w, h, k;
    w = frame_w();
    h = frame_h();
    if (flush_left > 0) begin
      k = w + 1 - flush_left;
      if (k < w) advance_raster(k, h, 32'd0);
      else advance_raster(0, h + 1, 32'd0);
      flush_left--;
      return;
    end
    if (it.drain) return;
    px = {rgb_only ? ALPHA_OPAQUE : it.alpha_in, it.blue_in, it.green_in, it.red_in};
    if (col_pos >= w || row_pos >= h) begin
      col_pos = 0;
      row_pos = 0;
    end
    advance_raster(col_pos, row_pos, px);
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) begin
        row_pos = 0;
        flush_left = w + 1;
      end
    end
  endfunction

  // Register write; also restarts the modeled frame.
  task automatic write_reg(cfg_idx_t idx, int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_IMAGE_WIDTH:   width_reg = value & 12'hFFF;
      CFG_IMAGE_HEIGHT:  height_reg = value & 13'h1FFF;
      CFG_THREE_CHANNEL: rgb_only = value[0];
      default: ;
    endcase
    col_pos = 0;
    row_pos = 0;
    flush_left = 0;
  endtask

  task automatic drain_out();
    in_valid <= 1'b0;
    while (owed_px.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_frame(int w, int h, int rgb);
    drain_out();
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_THREE_CHANNEL, rgb);
  endtask

  // Offer one item; called at a falling edge, returns at a falling edge.
  task automatic offer(in_item_t it, bit typed, out_item_t want);
    if (sender_gaps && !quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    fresh_px.delete();
    filter_step(it);
    if (typed) owed_px.push_back(want);
    else foreach (fresh_px[i]) owed_px.push_back(fresh_px[i]);
    @(negedge clk);
  endtask

  function automatic in_item_t make_px(bit drain);
    in_item_t it;
    int       kind;
    it = in_item_t'({1'b0, $urandom});
    it.drain = drain;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      it.red_in   = 8'($urandom_range(251, 255));
      it.green_in = 8'($urandom_range(0, 4));
      it.blue_in  = 8'($urandom_range(251, 255));
    end else if (kind < 45) begin
      it.alpha_in = 8'd0;
    end
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    out_item_t none;
    none = '0;
    offer(it, 1'b0, none);
    random_sent++;
    if (random_sent > QUIET_AFTER) quiet = 1'b1;
  endtask

  // A few frames with stray drains, dropped flush pixels and cut frames.
  task automatic run_frames(int w, int h);
    int frames;
    frames = $urandom_range(1, 3);
    for (int f = 0; f < frames; f++) begin
      for (int i = 0; i < w * h; i++) begin
        if ($urandom_range(0, 32) == 0) send_item(make_px(1'b1));
        send_item(make_px(1'b0));
      end
      for (int i = 0; i <= w; i++)
        send_item(make_px($urandom_range(0, 9) != 0));
    end
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, w * h)) send_item(make_px(1'b0));
  endtask

  // Receiver stall: random bursts, one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5) - 1) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each output transfer with the oldest owed pixel.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (owed_px.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected output %p", out_data);
      end else begin
        if (out_data !== owed_px[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: output mismatch, expected %p, got %p", owed_px[0], out_data);
        end
        void'(owed_px.pop_front());
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } step_row_t;

  // 1x1 frames: a pixel comes out on the second flush transfer.
  step_row_t directed[] = '{
    '{'{1'b0, 8'd10, 8'd20, 8'd30, 8'd40}, 1'b0, '0},
    '{'{1'b1, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
    '{'{1'b1, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1, '{8'd10, 8'd20, 8'd30, 8'd40, 1'b1}},
    '{'{1'b1, 8'd7, 8'd7, 8'd7, 8'd7}, 1'b0, '0},
    '{'{1'b0, 8'd255, 8'd0, 8'd255, 8'd255}, 1'b0, '0},
    '{'{1'b0, 8'd1, 8'd2, 8'd3, 8'd4}, 1'b0, '0},
    '{'{1'b1, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1, '{8'd255, 8'd0, 8'd255, 8'd0, 1'b1}},
    '{'{1'b0, 8'd251, 8'd4, 8'd251, 8'd0}, 1'b0, '0},
    '{'{1'b1, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
    '{'{1'b1, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1, '{8'd251, 8'd4, 8'd251, 8'd0, 1'b1}},
    '{'{1'b0, 8'd250, 8'd4, 8'd251, 8'd9}, 1'b0, '0},
    '{'{1'b1, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
    '{'{1'b1, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1, '{8'd250, 8'd4, 8'd251, 8'd9, 1'b1}},
    '{'{1'b0, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b0, '0},
    '{'{1'b1, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
    '{'{1'b1, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1, '{8'd255, 8'd255, 8'd255, 8'd255, 1'b1}},
    '{'{1'b0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
    '{'{1'b1, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
    '{'{1'b1, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1, '{8'd0, 8'd0, 8'd0, 8'd0, 1'b1}}
  };

  // Main sequence: reset, directed rows, extreme frames, random frames.
  initial begin
    int phase;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_req = 1'b0;
    quiet = 1'b0;
    sender_gaps = 1'b1;
    mismatches = 0;
    random_sent = 0;
    width_reg = 640;
    height_reg = 480;
    rgb_only = 1'b0;
    col_pos = 0;
    row_pos = 0;
    flush_left = 0;
    foreach (window[i]) window[i] = '0;
    foreach (row_above[i]) row_above[i] = '0;
    foreach (row_prev[i]) row_prev[i] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_frame(1, 1, 0);
    foreach (directed[i]) offer(directed[i].item, directed[i].typed, directed[i].want);

    // Register extremes: width and height clamp at both ends, on cut frames.
    set_frame(12'hFFF, 0, 1);
    repeat (EXTREME_ITEMS) send_item(make_px(1'b0));
    set_frame(0, 13'h1FFF, 0);
    repeat (EXTREME_ITEMS) send_item(make_px(1'b0));

    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      set_frame($urandom_range(1, 8), $urandom_range(1, 6), $urandom_range(0, 1));
      sender_gaps = $urandom_range(0, 3) != 0;
      if (phase == 3) hold_req = 1'b1;
      run_frames(frame_w(), frame_h());
      phase++;
    end

    in_valid <= 1'b0;
    while (owed_px.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && owed_px.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/ckeb_pkg.sv
rtl/core/ckeb_front.sv
rtl/core/ckeb_queue.sv
rtl/core/ckeb_back.sv
rtl/core/color_key_edge_bleed_filter.sv
tb/sv/color_key_edge_bleed_filter_test.sv
